/* hw/rtl/optimal_merge_cost_min_heap_macros.svh */
// Assertion macros used by the checker file of the merge-cost heap block.
`ifndef OPTIMAL_MERGE_COST_MIN_HEAP_MACROS_SVH
`define OPTIMAL_MERGE_COST_MIN_HEAP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hw/rtl/omc_pkg.sv */
// Package with widths, state and command types of the merge-cost heap block.
`timescale 1ns / 1ps

package omc_pkg;

    localparam int FSIZE_W = 16;
    localparam int SIZE_W  = 21;
    localparam int COST_W  = 26;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_STEP,
        S_UP_CMP,
        S_START,
        S_SINGLE,
        S_POP_RD,
        S_POP_TAKE,
        S_DN_RD,
        S_DN_CMP,
        S_MERGE,
        S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DROP,
        OP_UP_STEP,
        OP_UP_CMP,
        OP_RD_ROOT,
        OP_SINGLE,
        OP_POP_RD,
        OP_POP_TAKE,
        OP_DN_RD,
        OP_DN_CMP,
        OP_MERGE,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   second;
        logic   merging;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic cnt_le1;
        logic cnt_zero;
        logic pos_zero;
        logic up_stop;
        logic dn_stop;
        logic out_free;
    } t_dp_sts;

endpackage

/* hw/rtl/omc_file_if.sv */
// Valid/ready channel that carries one file size per transaction.
`timescale 1ns / 1ps

interface omc_file_if;
    import omc_pkg::*;

    logic               valid;
    logic               ready;
    logic [FSIZE_W-1:0] file_size;
    logic               last_file;

    modport source (output valid, output file_size, output last_file, input ready);
    modport sink   (input valid, input file_size, input last_file, output ready);
endinterface

/* hw/rtl/omc_result_if.sv */
// Valid/ready channel that carries one merge result per transaction.
`timescale 1ns / 1ps

interface omc_result_if;
    import omc_pkg::*;

    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] first_size;
    logic [SIZE_W-1:0] second_size;
    logic [SIZE_W-1:0] merged_size;
    logic [COST_W-1:0] running_cost;
    logic              merge_valid;
    logic              overflow;
    logic              last_result;

    modport source (
        output valid, output first_size, output second_size, output merged_size,
        output running_cost, output merge_valid, output overflow, output last_result,
        input ready
    );
    modport sink (
        input valid, input first_size, input second_size, input merged_size,
        input running_cost, input merge_valid, input overflow, input last_result,
        output ready
    );
endinterface

/* hw/rtl/omc_ctrl.sv */
// Controller state machine that sequences loading, heap sifts and merges.
`timescale 1ns / 1ps

module omc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    output logic             o_in_ready,
    input  omc_pkg::t_dp_sts i_sts,
    output omc_pkg::t_dp_cmd o_cmd
);
    import omc_pkg::*;

    t_state r_state, n_state;
    logic   r_last, n_last;
    logic   r_merging, n_merging;
    logic   r_second, n_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_last    <= 1'b0;
            r_merging <= 1'b0;
            r_second  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_last    <= n_last;
            r_merging <= n_merging;
            r_second  <= n_second;
        end
    end

    // Next state and the control flags that go with it.
    always_comb begin
        t_state after_push;
        t_state after_pop;
        logic   pop_second;

        n_state   = r_state;
        n_last    = r_last;
        n_merging = r_merging;
        n_second  = r_second;

        after_push = r_merging ? S_EMIT : (r_last ? S_START : S_IDLE);
        after_pop  = r_second ? S_MERGE : S_POP_RD;
        pop_second = !r_second;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_last = i_in_last;
                    if (i_sts.full) begin
                        n_state = i_in_last ? S_START : S_IDLE;
                    end else begin
                        n_state = S_UP_STEP;
                    end
                end
            end
            S_UP_STEP: begin
                n_state = i_sts.pos_zero ? after_push : S_UP_CMP;
            end
            S_UP_CMP: begin
                n_state = i_sts.up_stop ? after_push : S_UP_STEP;
            end
            S_START: begin
                if (i_sts.cnt_le1) begin
                    n_state = S_SINGLE;
                end else begin
                    n_state   = S_POP_RD;
                    n_merging = 1'b1;
                    n_second  = 1'b0;
                end
            end
            S_SINGLE: begin
                n_state = S_EMIT;
            end
            S_POP_RD: begin
                n_state = S_POP_TAKE;
            end
            S_POP_TAKE: begin
                if (i_sts.cnt_zero) begin
                    n_state  = after_pop;
                    n_second = pop_second;
                end else begin
                    n_state = S_DN_RD;
                end
            end
            S_DN_RD: begin
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (i_sts.dn_stop) begin
                    n_state  = after_pop;
                    n_second = pop_second;
                end else begin
                    n_state = S_DN_RD;
                end
            end
            S_MERGE: begin
                n_state = S_UP_STEP;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    if (i_sts.cnt_le1) begin
                        n_state   = S_IDLE;
                        n_merging = 1'b0;
                        n_last    = 1'b0;
                    end else begin
                        n_state  = S_POP_RD;
                        n_second = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath command for the current state.
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.op      = OP_NONE;
        o_cmd.second  = r_second;
        o_cmd.merging = r_merging;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = i_sts.full ? OP_DROP : OP_LOAD;
                end
            end
            S_UP_STEP:  o_cmd.op = OP_UP_STEP;
            S_UP_CMP:   o_cmd.op = OP_UP_CMP;
            S_START:    o_cmd.op = OP_RD_ROOT;
            S_SINGLE:   o_cmd.op = OP_SINGLE;
            S_POP_RD:   o_cmd.op = OP_POP_RD;
            S_POP_TAKE: o_cmd.op = OP_POP_TAKE;
            S_DN_RD:    o_cmd.op = OP_DN_RD;
            S_DN_CMP:   o_cmd.op = OP_DN_CMP;
            S_MERGE:    o_cmd.op = OP_MERGE;
            S_EMIT:     o_cmd.op = OP_EMIT;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

endmodule

/* hw/rtl/omc_datapath.sv */
// Datapath with the heap memory, sift pointers, merge adder and result register.
`timescale 1ns / 1ps

module omc_datapath #(
    parameter int HEAP_DEPTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  omc_pkg::t_dp_cmd             i_cmd,
    output omc_pkg::t_dp_sts             o_sts,
    input  logic [omc_pkg::FSIZE_W-1:0]  i_file_size,
    omc_result_if.source                 o_result
);
    import omc_pkg::*;

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int IW = CW + 1;

    logic [SIZE_W-1:0] r_mem [HEAP_DEPTH];
    logic [SIZE_W-1:0] r_rd0, r_rd1;

    logic [CW-1:0]     r_count;
    logic [COST_W-1:0] r_cost;
    logic              r_drop;
    logic [AW-1:0]     r_pos;
    logic [SIZE_W-1:0] r_val, r_a, r_b, r_m;

    logic              r_out_valid;
    logic [SIZE_W-1:0] r_out_first, r_out_second, r_out_merged;
    logic [COST_W-1:0] r_out_cost;
    logic              r_out_mvalid, r_out_ovf, r_out_last;

    logic [AW-1:0]     w_parent;
    logic [IW-1:0]     w_lidx, w_ridx;
    logic              w_l_ok, w_r_ok;
    logic              w_best_l, w_best_r;
    logic [SIZE_W-1:0] w_best_lv, w_child;
    logic [AW-1:0]     w_child_pos;
    logic [SIZE_W-1:0] w_sum;
    logic              w_out_free;

    logic              w_we;
    logic [AW-1:0]     w_wa, w_ra0, w_ra1;
    logic [SIZE_W-1:0] w_wd;

    assign w_parent = (r_pos - AW'(1)) >> 1;
    assign w_lidx   = (IW'(r_pos) << 1) + IW'(1);
    assign w_ridx   = w_lidx + IW'(1);
    assign w_l_ok   = w_lidx < IW'(r_count);
    assign w_r_ok   = w_ridx < IW'(r_count);

    // Child compare for the sift-down step: ties keep the hole, then the left child.
    assign w_best_l    = w_l_ok && (r_rd0 < r_val);
    assign w_best_lv   = w_best_l ? r_rd0 : r_val;
    assign w_best_r    = w_r_ok && (r_rd1 < w_best_lv);
    assign w_child     = w_best_r ? r_rd1 : r_rd0;
    assign w_child_pos = w_best_r ? w_ridx[AW-1:0] : w_lidx[AW-1:0];

    assign w_sum      = r_a + r_b;
    assign w_out_free = !r_out_valid || o_result.ready;

    assign o_sts.full     = r_count == CW'(HEAP_DEPTH);
    assign o_sts.cnt_le1  = r_count <= CW'(1);
    assign o_sts.cnt_zero = r_count == '0;
    assign o_sts.pos_zero = r_pos == '0;
    assign o_sts.up_stop  = r_rd0 <= r_val;
    assign o_sts.dn_stop  = !w_best_l && !w_best_r;
    assign o_sts.out_free = w_out_free;

    // Memory port addresses and the single write per cycle.
    always_comb begin
        w_we  = 1'b0;
        w_wa  = r_pos;
        w_wd  = r_val;
        w_ra0 = '0;
        w_ra1 = '0;
        unique case (i_cmd.op)
            OP_UP_STEP: begin
                if (r_pos == '0) begin
                    w_we = 1'b1;
                end else begin
                    w_ra0 = w_parent;
                end
            end
            OP_UP_CMP: begin
                w_we = 1'b1;
                w_wd = (r_rd0 <= r_val) ? r_val : r_rd0;
            end
            OP_POP_RD: begin
                w_ra1 = r_count[AW-1:0] - AW'(1);
            end
            OP_DN_RD: begin
                w_ra0 = w_l_ok ? w_lidx[AW-1:0] : '0;
                w_ra1 = w_r_ok ? w_ridx[AW-1:0] : '0;
            end
            OP_DN_CMP: begin
                w_we = 1'b1;
                w_wd = (!w_best_l && !w_best_r) ? r_val : w_child;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd0 <= r_mem[w_ra0];
        r_rd1 <= r_mem[w_ra1];
    end

    // Counter, cost and overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cost  <= '0;
            r_drop  <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_LOAD:   r_count <= r_count + CW'(1);
                OP_DROP:   r_drop  <= 1'b1;
                OP_POP_RD: r_count <= r_count - CW'(1);
                OP_MERGE: begin
                    r_count <= r_count + CW'(1);
                    r_cost  <= r_cost + COST_W'(w_sum);
                end
                OP_EMIT: begin
                    if (w_out_free && (r_count <= CW'(1))) begin
                        r_count <= '0;
                        r_cost  <= '0;
                        r_drop  <= 1'b0;
                    end
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    // Sift pointer, moving value and the operands of the current merge.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_val <= SIZE_W'(i_file_size);
                r_pos <= r_count[AW-1:0];
            end
            OP_UP_CMP: begin
                if (r_rd0 > r_val) begin
                    r_pos <= w_parent;
                end
            end
            OP_SINGLE: begin
                r_a <= (r_count == '0) ? '0 : r_rd0;
                r_b <= '0;
                r_m <= '0;
            end
            OP_POP_TAKE: begin
                if (i_cmd.second) begin
                    r_b <= r_rd0;
                end else begin
                    r_a <= r_rd0;
                end
                r_val <= r_rd1;
                r_pos <= '0;
            end
            OP_DN_CMP: begin
                if (w_best_l || w_best_r) begin
                    r_pos <= w_child_pos;
                end
            end
            OP_MERGE: begin
                r_m   <= w_sum;
                r_val <= w_sum;
                r_pos <= r_count[AW-1:0];
            end
            default: begin
                r_pos <= r_pos;
            end
        endcase
    end

    // Result register: the next merge proceeds while a result waits here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.op == OP_EMIT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.op == OP_EMIT) && w_out_free) begin
            r_out_first  <= r_a;
            r_out_second <= r_b;
            r_out_merged <= r_m;
            r_out_cost   <= r_cost;
            r_out_mvalid <= i_cmd.merging;
            r_out_ovf    <= r_drop;
            r_out_last   <= r_count <= CW'(1);
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.first_size   = r_out_first;
    assign o_result.second_size  = r_out_second;
    assign o_result.merged_size  = r_out_merged;
    assign o_result.running_cost = r_out_cost;
    assign o_result.merge_valid  = r_out_mvalid;
    assign o_result.overflow     = r_out_ovf;
    assign o_result.last_result  = r_out_last;

endmodule

/* hw/rtl/optimal_merge_cost_min_heap.sv */
// Top level of the optimal merge cost block built on a binary min-heap.
//
//  Channel   Direction  Transaction carries
//  i_file    in         file_size, last_file
//  o_result  out        first_size, second_size, merged_size, running_cost,
//                       merge_valid, overflow, last_result
//
// An accepted file size climbs with a parent read and a compare per level, or is
// written when it ends at the root. A merge takes two pops (a read and a take,
// then a child read and a compare per level down), an add step, the same sift-up
// without the accept and an emit step; the two read ports are registered.
// No input is taken while merges run. Reset is synchronous with no clearing
// pass; a stalled result waits in the output register while the next merge runs.
`timescale 1ns / 1ps

module optimal_merge_cost_min_heap #(
    parameter int HEAP_DEPTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    omc_file_if.sink      i_file,
    omc_result_if.source  o_result
);
    import omc_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    assign i_file.ready = w_in_ready;

    omc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_file.valid),
        .i_in_last  (i_file.last_file),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    omc_datapath #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_file_size (i_file.file_size),
        .o_result    (o_result)
    );

endmodule

/* hw/rtl/omc_checker.sv */
// Port-level checker for the merge-cost heap block and its bind statement.
`timescale 1ns / 1ps
`include "optimal_merge_cost_min_heap_macros.svh"

module omc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_in_last,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [omc_pkg::SIZE_W-1:0]  i_first,
    input logic [omc_pkg::SIZE_W-1:0]  i_second,
    input logic [omc_pkg::SIZE_W-1:0]  i_merged,
    input logic [omc_pkg::COST_W-1:0]  i_cost,
    input logic                        i_merge_valid,
    input logic                        i_last_result
);
    import omc_pkg::*;

    // A waiting result is not withdrawn.
    `OMC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // The final file of a set starts the merges, so no file is taken next cycle.
    `OMC_ASSERT_NXT(a_busy_after_last, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_last, !i_in_ready)

    // A real merge pops in ascending order and reports their wrapped sum.
    `OMC_ASSERT_IMP(a_merge_sum, i_clk, i_rst_n, i_out_valid && i_merge_valid, (i_first <= i_second) && (i_merged == SIZE_W'(i_first + i_second)))

    // A set without a merge gives one final result with zero cost.
    `OMC_ASSERT_IMP(a_single_file, i_clk, i_rst_n, i_out_valid && !i_merge_valid, i_last_result && (i_second == '0) && (i_merged == '0) && (i_cost == '0))

endmodule

bind optimal_merge_cost_min_heap omc_checker u_omc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_file.valid),
    .i_in_ready    (i_file.ready),
    .i_in_last     (i_file.last_file),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_first       (o_result.first_size),
    .i_second      (o_result.second_size),
    .i_merged      (o_result.merged_size),
    .i_cost        (o_result.running_cost),
    .i_merge_valid (o_result.merge_valid),
    .i_last_result (o_result.last_result)
);
